// ===== hw/rtl/fpdt_pkg.sv =====
// Package for the fixed-point to decimal text converter.
// Holds the controller states, the command and status words between the
// controller and the datapath, the character codes and parameter defaults.
package fpdt_pkg;

    // Width of the input data word.
    localparam int WORD_BITS = 32;

    // Parameter defaults for the top level.
    localparam int DEF_INT_BITS  = 24;
    localparam int DEF_FRAC_BITS = 7;

    // ASCII codes, six bits wide.
    localparam logic [5:0] CH_MINUS = 6'd45;
    localparam logic [5:0] CH_DOT   = 6'd46;
    localparam logic [5:0] CH_ZERO  = 6'd48;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_INT,
        ST_DOT,
        ST_FRAC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_sign;
        logic emit_int;
        logic emit_dot;
        logic emit_frac;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic neg;
        logic conv_done;
        logic lead_zero;
        logic int_one_left;
        logic frac_last;
    } t_status;

endpackage

// ===== hw/rtl/fpdt_ctrl.sv =====
// Controller state machine of the fixed-point to decimal text converter.
// Sequences load, BCD conversion, leading-zero skip and character output.
// Depends on fpdt_pkg.
module fpdt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fpdt_pkg::t_status i_status,
    output fpdt_pkg::t_cmd    o_cmd
);
    import fpdt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (i_status.conv_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!i_status.lead_zero) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                n_state = ST_INT;
            end
            ST_INT: begin
                if (i_status.int_one_left) begin
                    n_state = ST_DOT;
                end
            end
            ST_DOT: begin
                n_state = ST_FRAC;
            end
            ST_FRAC: begin
                if (i_status.frac_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd = '{default: 1'b0};
        unique case (r_state)
            ST_IDLE: o_cmd.load      = start;
            ST_CONV: o_cmd.conv_step = 1'b1;
            ST_SKIP: o_cmd.skip_step = i_status.lead_zero;
            ST_SIGN: o_cmd.emit_sign = i_status.neg;
            ST_INT:  o_cmd.emit_int  = 1'b1;
            ST_DOT:  o_cmd.emit_dot  = 1'b1;
            ST_FRAC: o_cmd.emit_frac = 1'b1;
            default: o_cmd = '{default: 1'b0};
        endcase
    end

    // No word is taken while reset is applied.
    assign busy = (r_state != ST_IDLE) || !i_rst_n;

endmodule

// ===== hw/rtl/fpdt_datapath.sv =====
// Datapath of the fixed-point to decimal text converter: double-dabble
// BCD register, fraction multiply-by-ten and the output character register.
// Depends on fpdt_pkg.
module fpdt_datapath #(
    parameter int INT_BITS  = fpdt_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS = fpdt_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [fpdt_pkg::WORD_BITS-1:0] i_data_word,
    input  fpdt_pkg::t_cmd                 i_cmd,
    output fpdt_pkg::t_status              o_status,
    output logic                           o_valid,
    output logic [5:0]                     o_text_char,
    output logic                           o_last_char
);
    import fpdt_pkg::*;

    // Decimal digits needed for INT_BITS bits: floor(INT_BITS*log10(2)) + 1.
    localparam int NDIG     = (INT_BITS * 30103) / 100000 + 1;
    localparam int BW       = NDIG * 4;
    localparam int CW       = $clog2(INT_BITS + 1);
    localparam int DW       = $clog2(NDIG + 1);
    localparam int SIGN_POS = INT_BITS + FRAC_BITS;

    logic [2*WORD_BITS-1:0] w_word;
    logic [INT_BITS-1:0]    r_bin,  n_bin;
    logic [BW-1:0]          r_bcd,  n_bcd;
    logic [BW-1:0]          w_adj;
    logic [CW-1:0]          r_cnt,  n_cnt;
    logic [DW-1:0]          r_left, n_left;
    logic [FRAC_BITS-1:0]   r_frac, n_frac;
    logic                   r_neg,  n_neg;
    logic [FRAC_BITS+3:0]   w_prod;
    logic [3:0]             w_top;
    logic                   r_valid, n_valid;
    logic [5:0]             r_char,  n_char;
    logic                   r_last,  n_last;

    // Zero-extended word, so that bits past the top read as zero.
    assign w_word = {{WORD_BITS{1'b0}}, i_data_word};

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        w_adj = r_bcd;
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end
        end
    end

    // Fraction times ten: the upper four bits are the next digit.
    assign w_prod = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};
    assign w_top  = r_bcd[BW-1 -: 4];

    // Status for the controller.
    assign o_status.neg          = r_neg;
    assign o_status.conv_done    = (r_cnt == CW'(INT_BITS - 1));
    assign o_status.lead_zero    = (w_top == 4'd0) && (r_left > DW'(1));
    assign o_status.int_one_left = (r_left == DW'(1));
    assign o_status.frac_last    = (w_prod[FRAC_BITS-1:0] == '0);

    // Next values of the working registers and the output word.
    always_comb begin
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_frac  = r_frac;
        n_neg   = r_neg;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = 1'b0;
        if (i_cmd.load) begin
            n_bin  = w_word[FRAC_BITS +: INT_BITS];
            n_frac = w_word[FRAC_BITS-1:0];
            n_neg  = w_word[SIGN_POS];
            n_bcd  = '0;
            n_cnt  = '0;
            n_left = DW'(NDIG);
        end
        if (i_cmd.conv_step) begin
            n_bcd = {w_adj[BW-2:0], r_bin[INT_BITS-1]};
            n_bin = r_bin << 1;
            n_cnt = r_cnt + CW'(1);
        end
        if (i_cmd.skip_step || i_cmd.emit_int) begin
            n_bcd  = r_bcd << 4;
            n_left = r_left - DW'(1);
        end
        if (i_cmd.emit_sign) begin
            n_valid = 1'b1;
            n_char  = CH_MINUS;
        end
        if (i_cmd.emit_int) begin
            n_valid = 1'b1;
            n_char  = CH_ZERO + {2'b00, w_top};
        end
        if (i_cmd.emit_dot) begin
            n_valid = 1'b1;
            n_char  = CH_DOT;
        end
        if (i_cmd.emit_frac) begin
            n_valid = 1'b1;
            n_char  = CH_ZERO + {2'b00, w_prod[FRAC_BITS +: 4]};
            n_last  = o_status.frac_last;
            n_frac  = w_prod[FRAC_BITS-1:0];
        end
    end

    // Only the output strobe needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_frac <= n_frac;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

endmodule

// ===== hw/rtl/fixed_point_to_decimal_text_core.sv =====
// Fixed-point to decimal text converter, top level: one word in, one ASCII character per strobe.
// Sequence after the accepting edge: BCD conversion of the integer part, then Z leading zero
// digits skipped one per cycle, then the minus sign state, the integer digits, the dot and the
// fraction digits; after the first digit the rest follow one per cycle. A new word is taken only
// once busy has fallen after the last character (NDIG = 8 digit slots). The receiver cannot stall.
// Synchronous active-low reset idles the controller, clears the strobe and holds busy high.
module fixed_point_to_decimal_text_core #(
    parameter int INT_BITS  = fpdt_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS = fpdt_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [fpdt_pkg::WORD_BITS-1:0] i_data_word,
    output logic                           o_valid,
    output logic [5:0]                     o_text_char,
    output logic                           o_last_char
);
    import fpdt_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Controller.
    fpdt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath.
    fpdt_datapath #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_word (i_data_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
